// File: design/secu_pkg.sv
`timescale 1ns / 1ps

package secu_pkg;

    localparam int NUM_TERMS  = 3;
    localparam int TERM_SLOTS = 3;
    localparam int TERM_W     = 2;

    localparam logic [1:0] FUNC_EVENT  = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_REWIND = 2'd2;

    localparam logic [2:0] CFG_INTENSITY_0 = 3'd0;
    localparam logic [2:0] CFG_INTENSITY_1 = 3'd1;
    localparam logic [2:0] CFG_INTENSITY_2 = 3'd2;
    localparam logic [2:0] CFG_DECAY_0     = 3'd3;
    localparam logic [2:0] CFG_DECAY_1     = 3'd4;
    localparam logic [2:0] CFG_DECAY_2     = 3'd5;

    // exp(-1) in Q.32 as given by the truncated series.
    localparam logic [32:0] EXP_ONE   = 33'd1580030169;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [3:0]  LAST_K    = 4'd14;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] event_time;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] convolution;
        logic signed [47:0] positive_bound;
        logic signed [47:0] primitive_res;
        logic               time_error;
    } t_out_item;

endpackage

// File: design/sum_exp_event_convolution_unit.sv
`timescale 1ns / 1ps

// Each item is worked through on one shared 34x34 multiplier. A rewind or a time error goes
// straight from idle to the done state, where its result is loaded once the output is free. An
// event or query computes, per term, the exponent, then 14 series steps (each one multiply and
// a divider that retires 8 quotient bits a cycle), then one multiply by exp(-1) per whole unit
// of the exponent (up to 31), then the decay product. A term whose exponent reaches 32 skips
// the series and the powers. The output products are then formed term by term. The input is
// stalled until the result is loaded.
module sum_exp_event_convolution_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  secu_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output secu_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import secu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_X_MUL, S_X_USE, S_E_MUL, S_E_LOAD, S_E_DIV, S_E_ACC,
        S_P_MUL, S_P_USE, S_D_MUL, S_D_USE, S_FIN,
        S_O_AB, S_O_ABS, S_O_AC, S_O_AS, S_O_PRIM, S_DONE
    } t_state;

    t_state                    r_state;
    logic signed [15:0]        r_int [TERM_SLOTS];
    logic [15:0]               r_dec [TERM_SLOTS];
    logic [31:0]               r_sum [TERM_SLOTS];
    logic [31:0]               r_last;
    logic [31:0]               r_cnt;
    logic [1:0]                r_func;
    logic [31:0]               r_time;
    logic [TERM_W-1:0]         r_i;
    logic signed [67:0]        r_prod;
    logic [15:0]               r_f;
    logic [4:0]                r_j;
    logic [32:0]               r_term;
    logic signed [35:0]        r_acc;
    logic [3:0]                r_k;
    logic [39:0]               r_dvd;
    logic [39:0]               r_quo;
    logic [3:0]                r_rem;
    logic [2:0]                r_dc;
    logic [32:0]               r_fac;
    logic signed [48:0]        r_ac;
    logic signed [55:0]        r_conv;
    logic signed [55:0]        r_bound;
    logic signed [55:0]        r_prim;
    logic                      r_err;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic signed [33:0]        mul_a;
    logic signed [33:0]        mul_b;
    logic [31:0]               delay;
    logic signed [15:0]        cur_int;
    logic [15:0]               cur_dec;
    logic [31:0]               cur_sum;
    logic [39:0]               n_dvd;
    logic [39:0]               n_quo;
    logic [3:0]                n_rem;
    logic [4:0]                rem5;
    logic signed [35:0]        n_acc;
    logic [32:0]               n_fac;
    logic [32:0]               dsum;
    logic signed [55:0]        c_term;
    logic signed [65:0]        p_full;
    logic signed [55:0]        p_term;
    logic                      out_free;

    function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
        if (v > 56'sh00_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -56'sh00_8000_0000_0000) begin
            return -48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    assign delay   = r_time - r_last;
    assign cur_int = r_int[r_i];
    assign cur_dec = r_dec[r_i];
    assign cur_sum = r_sum[r_i];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_X_MUL: begin
                mul_a = {18'd0, cur_dec};
                mul_b = {2'd0, delay};
            end
            S_E_MUL: begin
                mul_a = {1'b0, r_term};
                mul_b = {18'd0, r_f};
            end
            S_P_MUL: begin
                mul_a = {1'b0, r_fac};
                mul_b = {1'b0, EXP_ONE};
            end
            S_D_MUL: begin
                mul_a = {2'd0, cur_sum};
                mul_b = {1'b0, r_fac};
            end
            S_O_AB: begin
                mul_a = 34'(cur_int);
                mul_b = {18'd0, cur_dec};
            end
            S_O_ABS: begin
                mul_a = 34'(signed'(r_prod[32:0]));
                mul_b = {2'd0, cur_sum};
            end
            S_O_AC: begin
                mul_a = 34'(cur_int);
                mul_b = {2'd0, r_cnt};
            end
            S_O_AS: begin
                mul_a = 34'(cur_int);
                mul_b = {2'd0, cur_sum};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_dvd = r_dvd;
        n_quo = r_quo;
        n_rem = r_rem;
        rem5  = '0;
        for (int b = 0; b < 8; b++) begin
            rem5  = {n_rem, n_dvd[39]};
            n_dvd = {n_dvd[38:0], 1'b0};
            if (rem5 >= {1'b0, r_k}) begin
                n_rem = 4'(rem5 - {1'b0, r_k});
                n_quo = {n_quo[38:0], 1'b1};
            end else begin
                n_rem = rem5[3:0];
                n_quo = {n_quo[38:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_k[0]) begin
            n_acc = r_acc - 36'(r_quo[32:0]);
        end else begin
            n_acc = r_acc + 36'(r_quo[32:0]);
        end
        if (n_acc < 0) begin
            n_fac = '0;
        end else if (n_acc > 36'(ONE_Q32)) begin
            n_fac = ONE_Q32;
        end else begin
            n_fac = n_acc[32:0];
        end
    end

    assign dsum   = {1'b0, r_prod[63:32]} + 33'h0_0001_0000;
    assign c_term = 56'(r_prod >>> 20);
    assign p_full = (66'(r_ac) <<< 16) - 66'(signed'(r_prod[48:0]));
    assign p_term = 56'(p_full >>> 12);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_cnt       <= '0;
            r_i         <= '0;
            for (int t = 0; t < TERM_SLOTS; t++) begin
                r_sum[t] <= '0;
                r_int[t] <= (t == 0) ? 16'sd4096 : 16'sd0;
                r_dec[t] <= 16'd256;
            end
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INTENSITY_0: r_int[0] <= i_cfg_data;
                    CFG_INTENSITY_1: r_int[1] <= i_cfg_data;
                    CFG_INTENSITY_2: r_int[2] <= i_cfg_data;
                    CFG_DECAY_0:     r_dec[0] <= i_cfg_data;
                    CFG_DECAY_1:     r_dec[1] <= i_cfg_data;
                    CFG_DECAY_2:     r_dec[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_in.func;
                        r_time  <= i_in.event_time;
                        r_i     <= '0;
                        r_conv  <= '0;
                        r_bound <= '0;
                        r_prim  <= '0;
                        r_err   <= 1'b0;
                        if (i_in.func == FUNC_REWIND) begin
                            for (int t = 0; t < TERM_SLOTS; t++) begin
                                r_sum[t] <= '0;
                            end
                            r_last  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DONE;
                        end else if (i_in.event_time < r_last) begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_X_MUL;
                        end
                    end
                end
                S_X_MUL: r_state <= S_X_USE;
                S_X_USE: begin
                    r_f    <= r_prod[23:8];
                    r_j    <= r_prod[28:24];
                    r_term <= ONE_Q32;
                    r_acc  <= 36'(ONE_Q32);
                    r_k    <= 4'd1;
                    if (|r_prod[47:29]) begin
                        r_fac   <= '0;
                        r_state <= S_D_MUL;
                    end else begin
                        r_state <= S_E_MUL;
                    end
                end
                S_E_MUL: r_state <= S_E_LOAD;
                S_E_LOAD: begin
                    r_dvd   <= {7'd0, r_prod[48:16]};
                    r_quo   <= '0;
                    r_rem   <= '0;
                    r_dc    <= '0;
                    r_state <= S_E_DIV;
                end
                S_E_DIV: begin
                    r_dvd <= n_dvd;
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_dc  <= r_dc + 3'd1;
                    if (r_dc == 3'd4) begin
                        r_state <= S_E_ACC;
                    end
                end
                S_E_ACC: begin
                    r_acc  <= n_acc;
                    r_term <= r_quo[32:0];
                    if (r_k == LAST_K) begin
                        r_fac <= n_fac;
                        if (r_j == '0) begin
                            r_state <= S_D_MUL;
                        end else begin
                            r_state <= S_P_MUL;
                        end
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_E_MUL;
                    end
                end
                S_P_MUL: r_state <= S_P_USE;
                S_P_USE: begin
                    r_fac <= r_prod[64:32];
                    r_j   <= r_j - 5'd1;
                    if (r_j == 5'd1) begin
                        r_state <= S_D_MUL;
                    end else begin
                        r_state <= S_P_MUL;
                    end
                end
                S_D_MUL: r_state <= S_D_USE;
                S_D_USE: begin
                    if (r_func == FUNC_EVENT) begin
                        r_sum[r_i] <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
                    end else begin
                        r_sum[r_i] <= r_prod[63:32];
                    end
                    if (r_i == TERM_W'(NUM_TERMS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_X_MUL;
                    end
                end
                S_FIN: begin
                    if (r_func == FUNC_EVENT && r_cnt != 32'hFFFF_FFFF) begin
                        r_cnt <= r_cnt + 32'd1;
                    end
                    r_last  <= r_time;
                    r_i     <= '0;
                    r_state <= S_O_AB;
                end
                S_O_AB:  r_state <= S_O_ABS;
                S_O_ABS: r_state <= S_O_AC;
                S_O_AC: begin
                    r_conv <= r_conv + c_term;
                    if (cur_int > 0) begin
                        r_bound <= r_bound + c_term;
                    end
                    r_state <= S_O_AS;
                end
                S_O_AS: begin
                    r_ac    <= r_prod[48:0];
                    r_state <= S_O_PRIM;
                end
                S_O_PRIM: begin
                    r_prim <= r_prim + p_term;
                    if (r_i == TERM_W'(NUM_TERMS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_O_AB;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.convolution    <= sat48(r_conv);
                        r_out.positive_bound <= sat48(r_bound);
                        r_out.primitive_res  <= sat48(r_prim);
                        r_out.time_error     <= r_err;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> r_state == S_IDLE)
        else $error("input taken outside idle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.time_error) |->
        (o_out.convolution == 0 && o_out.positive_bound == 0 && o_out.primitive_res == 0))
        else $error("error result carries data");

    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in.func == FUNC_REWIND) |=>
        (r_cnt == 0 && r_last == 0 && r_state == S_DONE))
        else $error("rewind did not clear state");

    a_div_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_E_DIV |-> (r_k >= 4'd1 && r_k <= LAST_K))
        else $error("series divisor out of range");

endmodule

// File: tb/sum_exp_event_convolution_unit_test.sv
`timescale 1ns / 1ps

module sum_exp_event_convolution_unit_test;
    import secu_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int         CYCLE_LIMIT = 6000000;
    localparam int         LONG_HOLD = 6000;
    localparam int         ITEMS_PER_PHASE = 400;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] event_time;
        logic        typed;
        t_out_item   result;
    } t_stim_row;

    localparam t_out_item ZERO_RES = '{48'sd0, 48'sd0, 48'sd0, 1'b0};
    localparam t_out_item TIME_ERR = '{48'sd0, 48'sd0, 48'sd0, 1'b1};

    localparam t_stim_row DIRECTED [20] = '{
        '{FUNC_QUERY,  32'h0000_0000, 1'b1, ZERO_RES},
        '{FUNC_EVENT,  32'h0000_0000, 1'b0, ZERO_RES},
        '{FUNC_EVENT,  32'h0000_0000, 1'b0, ZERO_RES},
        '{FUNC_QUERY,  32'h0000_8000, 1'b0, ZERO_RES},
        '{FUNC_EVENT,  32'h0001_0000, 1'b0, ZERO_RES},
        '{2'd3,        32'h0001_0001, 1'b0, ZERO_RES},
        '{FUNC_QUERY,  32'h0000_FFFF, 1'b1, TIME_ERR},
        '{FUNC_EVENT,  32'h0000_0000, 1'b1, TIME_ERR},
        '{FUNC_EVENT,  32'h0003_0000, 1'b0, ZERO_RES},
        '{FUNC_QUERY,  32'h0020_0000, 1'b0, ZERO_RES},
        '{FUNC_EVENT,  32'h0020_0000, 1'b0, ZERO_RES},
        '{FUNC_EVENT,  32'hFFFF_FFFF, 1'b0, ZERO_RES},
        '{FUNC_QUERY,  32'hFFFF_FFFF, 1'b0, ZERO_RES},
        '{FUNC_EVENT,  32'h5555_AAAA, 1'b1, TIME_ERR},
        '{FUNC_REWIND, 32'hAAAA_5555, 1'b1, ZERO_RES},
        '{FUNC_QUERY,  32'h0000_0000, 1'b1, ZERO_RES},
        '{FUNC_EVENT,  32'h0000_0100, 1'b0, ZERO_RES},
        '{FUNC_EVENT,  32'h0000_0180, 1'b0, ZERO_RES},
        '{FUNC_QUERY,  32'h0000_C000, 1'b0, ZERO_RES},
        '{FUNC_REWIND, 32'h0000_0000, 1'b1, ZERO_RES}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sum_exp_event_convolution_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic signed [15:0] weight   [TERM_SLOTS];
    logic [15:0]        rate     [TERM_SLOTS];
    logic [31:0]        sums     [TERM_SLOTS];
    logic [31:0]        prev_time;
    logic [31:0]        events_seen;

    t_out_item pending_results [$];
    int        mismatches;
    int        results_checked;
    int        n_events, n_queries, n_errors, n_rewinds;
    int        hold_requests;
    logic      no_idle;
    longint    cycles = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint unsigned exp_fraction(longint unsigned f);
        longint unsigned term;
        longint          acc;
        term = 64'd1 << 32;
        acc = longint'(term);
        for (int k = 1; k <= 14; k++) begin
            term = (term * f) / (longint'(k) << 16);
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 32)) begin
            acc = 64'sd1 <<< 32;
        end
        return longint'(acc);
    endfunction

    function automatic longint unsigned decay_factor(longint unsigned x);
        longint unsigned whole;
        longint unsigned r;
        longint unsigned e1;
        whole = x >> 16;
        if (whole >= 32) begin
            return 0;
        end
        r = exp_fraction(x & 64'hFFFF);
        e1 = exp_fraction(64'd65536);
        for (longint unsigned j = 0; j < whole; j++) begin
            r = (r * e1) >> 32;
        end
        return r;
    endfunction

    function automatic logic signed [47:0] clamp48(longint v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end
        if (v < -64'sh0000_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    function automatic t_out_item intensity_update(t_in_item it);
        t_out_item       res;
        longint unsigned delay;
        longint unsigned s;
        longint          a, ab, c, diff;
        longint          conv, bound, prim;
        res = ZERO_RES;
        conv = 0;
        bound = 0;
        prim = 0;
        if (it.func == FUNC_REWIND) begin
            for (int i = 0; i < TERM_SLOTS; i++) begin
                sums[i] = '0;
            end
            prev_time = '0;
            events_seen = '0;
            return res;
        end
        if (it.event_time < prev_time) begin
            res.time_error = 1'b1;
            return res;
        end
        delay = it.event_time - prev_time;
        for (int i = 0; i < NUM_TERMS; i++) begin
            s = (longint'(sums[i]) * decay_factor((longint'(rate[i]) * delay) >> 8)) >> 32;
            if (it.func == FUNC_EVENT) begin
                s += 65536;
                if (s > 64'hFFFF_FFFF) begin
                    s = 64'hFFFF_FFFF;
                end
            end
            sums[i] = s[31:0];
        end
        if (it.func == FUNC_EVENT && events_seen != 32'hFFFF_FFFF) begin
            events_seen++;
        end
        prev_time = it.event_time;
        for (int i = 0; i < NUM_TERMS; i++) begin
            a = longint'(weight[i]);
            ab = a * longint'({16'd0, rate[i]});
            c = (ab * longint'({32'd0, sums[i]})) >>> 20;
            diff = (longint'({32'd0, events_seen}) << 16) - longint'({32'd0, sums[i]});
            conv += c;
            if (a > 0) begin
                bound += c;
            end
            prim += (a * diff) >>> 12;
        end
        res.convolution = clamp48(conv);
        res.positive_bound = clamp48(bound);
        res.primitive_res = clamp48(prim);
        return res;
    endfunction

    task automatic write_register(logic [2:0] index, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index <= CFG_INTENSITY_2) begin
            weight[index] = value;
        end else if (index <= CFG_DECAY_2) begin
            rate[index - CFG_DECAY_0] = value;
        end
    endtask

    task automatic offer_item(t_in_item it, logic typed, t_out_item typed_result);
        int gap;
        t_out_item predicted;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (it.func == FUNC_REWIND) begin
            n_rewinds++;
        end else if (it.event_time < prev_time) begin
            n_errors++;
        end else if (it.func == FUNC_EVENT) begin
            n_events++;
        end else begin
            n_queries++;
        end
        predicted = intensity_update(it);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        t_in_item    it;
        logic [31:0] now;
        int          pick;
        now = prev_time;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            it.event_time = now;
            if (pick < 4) begin
                it.func = FUNC_REWIND;
                it.event_time = $urandom();
                now = '0;
            end else if (pick < 8 && now != 0) begin
                it.func = ($urandom_range(0, 1) != 0) ? FUNC_EVENT : FUNC_QUERY;
                it.event_time = $urandom_range(0, now - 1);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    it.event_time = now + $urandom_range(0, 32'h3_FFFF);
                end else if (pick < 85) begin
                    it.event_time = now + $urandom_range(0, 255);
                end else if (pick < 95) begin
                    it.event_time = now + $urandom_range(0, 32'h00FF_FFFF);
                end else begin
                    it.event_time = now + $urandom();
                end
                pick = $urandom_range(0, 99);
                it.func = (pick < 70) ? FUNC_EVENT : (pick < 95) ? FUNC_QUERY : 2'd3;
                if (it.event_time >= now) begin
                    now = it.event_time;
                end
            end
            offer_item(it, 1'b0, ZERO_RES);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    int out_wait;
    int hold_left;
    int holds_seen;
    t_out_item wanted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait <= 0;
            hold_left <= 0;
            holds_seen <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result item: %p", o_out);
                    end
                end else begin
                    wanted = pending_results.pop_front();
                    if (o_out.convolution !== wanted.convolution
                            || o_out.positive_bound !== wanted.positive_bound
                            || o_out.primitive_res !== wanted.primitive_res
                            || o_out.time_error !== wanted.time_error) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: expected conv %0d bound %0d prim %0d err %0b",
                                     wanted.convolution, wanted.positive_bound,
                                     wanted.primitive_res, wanted.time_error);
                            $display("          actual   conv %0d bound %0d prim %0d err %0b",
                                     o_out.convolution, o_out.positive_bound,
                                     o_out.primitive_res, o_out.time_error);
                        end
                    end
                end
            end
            if (holds_seen != hold_requests) begin
                holds_seen <= hold_requests;
                hold_left <= LONG_HOLD;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                out_wait <= no_idle ? 0 : $urandom_range(0, 17);
                i_out_stall <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait <= out_wait - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INTENSITY_0;
        i_cfg_data = '0;
        no_idle = 1'b0;
        mismatches = 0;
        results_checked = 0;
        n_events = 0;
        n_queries = 0;
        n_errors = 0;
        n_rewinds = 0;
        hold_requests = 0;
        for (int i = 0; i < TERM_SLOTS; i++) begin
            weight[i] = '0;
            rate[i] = 16'd256;
            sums[i] = '0;
        end
        weight[0] = 16'sd4096;
        prev_time = '0;
        events_seen = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            it.func = DIRECTED[r].func;
            it.event_time = DIRECTED[r].event_time;
            offer_item(it, DIRECTED[r].typed, DIRECTED[r].result);
        end
        random_phase(ITEMS_PER_PHASE - 60);
        drain();

        write_register(CFG_INTENSITY_0, $urandom());
        write_register(CFG_INTENSITY_1, $urandom());
        write_register(CFG_INTENSITY_2, $urandom());
        write_register(CFG_DECAY_0, $urandom_range(0, 1024));
        write_register(CFG_DECAY_1, $urandom_range(0, 4096));
        write_register(CFG_DECAY_2, $urandom());
        write_register(CFG_UNUSED, $urandom());
        no_idle <= 1'b1;
        random_phase(100);
        no_idle <= 1'b0;
        hold_requests <= hold_requests + 1;
        random_phase(ITEMS_PER_PHASE - 100);
        drain();

        write_register(CFG_INTENSITY_0, 16'h7FFF);
        write_register(CFG_INTENSITY_1, 16'h8000);
        write_register(CFG_INTENSITY_2, 16'h7FFF);
        write_register(CFG_DECAY_0, 16'hFFFF);
        write_register(CFG_DECAY_1, 16'h0000);
        write_register(CFG_DECAY_2, 16'h0001);
        write_register(3'd7, 16'hFFFF);
        random_phase(ITEMS_PER_PHASE / 2);
        drain();
        random_phase(ITEMS_PER_PHASE / 2);
        drain();

        write_register(CFG_INTENSITY_0, 16'h8000);
        write_register(CFG_INTENSITY_1, $urandom());
        write_register(CFG_INTENSITY_2, 16'h8000);
        write_register(CFG_DECAY_0, 16'h0000);
        write_register(CFG_DECAY_1, 16'hFFFF);
        write_register(CFG_DECAY_2, $urandom_range(0, 512));
        random_phase(ITEMS_PER_PHASE);
        drain();

        repeat (600) @(posedge i_clk);
        $display("Covered %0d events, %0d queries, %0d time errors, %0d rewinds",
                 n_events, n_queries, n_errors, n_rewinds);
        $display("under four register settings; %0d results checked, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
